// ----- hdl/assert_macros.svh -----
// assertion macros for the rtl files
// depends on signals clk and rst in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// clocked check, disabled while reset is high
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// clocked check that also runs through reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- hdl/rialu_pkg.sv -----
// package for the integer alu core: transaction structs, operation codes, status layout
// no dependencies
`timescale 1ns / 1ps

package rialu_pkg;

  // operation codes
  localparam logic [4:0] K_ADD    = 5'd0;
  localparam logic [4:0] K_ADDI   = 5'd1;
  localparam logic [4:0] K_ADDC   = 5'd2;
  localparam logic [4:0] K_ADDV   = 5'd3;
  localparam logic [4:0] K_AND    = 5'd4;
  localparam logic [4:0] K_ANDI   = 5'd5;
  localparam logic [4:0] K_CMPEQ  = 5'd6;
  localparam logic [4:0] K_CMPGE  = 5'd7;
  localparam logic [4:0] K_CMPGT  = 5'd8;
  localparam logic [4:0] K_CMPHI  = 5'd9;
  localparam logic [4:0] K_CMPHS  = 5'd10;
  localparam logic [4:0] K_CMPPL  = 5'd11;
  localparam logic [4:0] K_CMPPZ  = 5'd12;
  localparam logic [4:0] K_CMPSTR = 5'd13;
  localparam logic [4:0] K_CMPIM  = 5'd14;
  localparam logic [4:0] K_DIV0S  = 5'd15;
  localparam logic [4:0] K_DIV0U  = 5'd16;
  localparam logic [4:0] K_DIV1   = 5'd17;
  localparam logic [4:0] K_DT     = 5'd18;
  localparam logic [4:0] K_EXTSB  = 5'd19;
  localparam logic [4:0] K_EXTSW  = 5'd20;
  localparam logic [4:0] K_EXTUB  = 5'd21;
  localparam logic [4:0] K_EXTUW  = 5'd22;
  localparam logic [4:0] K_MOV    = 5'd23;
  localparam logic [4:0] K_CLRT   = 5'd24;
  localparam logic [4:0] K_LDCSR  = 5'd25;
  localparam logic [4:0] K_LDB    = 5'd26;
  localparam logic [4:0] K_LDW    = 5'd27;
  localparam logic [4:0] K_LDL    = 5'd28;

  // status register layout
  localparam int SR_W   = 10;
  localparam int SR_T   = 0;
  localparam int SR_Q   = 8;
  localparam int SR_M   = 9;
  localparam logic [SR_W-1:0] SR_MASK = 10'h3F3;

  localparam int NREGS = 16;
  localparam int RIDX_W = 4;

  typedef struct packed {
    logic [4:0]  kind;
    logic [3:0]  dest_reg;
    logic [3:0]  src_reg;
    logic [7:0]  imm_byte;
    logic [31:0] load_data;
  } req_t;

  typedef struct packed {
    logic        reg_written;
    logic [3:0]  written_index;
    logic [31:0] written_value;
    logic        t_flag;
    logic        q_flag;
    logic        m_flag;
  } rsp_t;

  function automatic logic [31:0] sext8(input logic [7:0] v);
    sext8 = {{24{v[7]}}, v};
  endfunction

  function automatic logic [31:0] sext16(input logic [15:0] v);
    sext16 = {{16{v[15]}}, v};
  endfunction

endpackage

// ----- hdl/risc_integer_alu_with_flag_bits_core.sv -----
// integer alu core: register file memory, execute stage, output register
// depends on rialu_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The accept cycle reads the 16 x 32 register file into the read data registers, the execute
// stage then executes and writes back, and the result sits in the output register. Throughput
// is one instruction per cycle while the block is not stalled, set by the single write port
// of the register file; a result written back in the same cycle that a later instruction
// reads its operands is forwarded, so dependent instructions may follow each other directly.
// The register file is cleared at reset through per-entry valid bits, so no clearing pass is
// needed. The block stalls only when the output register is full and not being taken.
module risc_integer_alu_with_flag_bits_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  rialu_pkg::req_t  req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rialu_pkg::rsp_t  rsp
);

  // register file and its valid bits
  logic [31:0]                  mem [rialu_pkg::NREGS];
  logic [rialu_pkg::NREGS-1:0]  vld;

  // execute stage registers
  logic                         s1_v;
  logic [4:0]                   s1_kind;
  logic [3:0]                   s1_dest;
  logic [7:0]                   s1_imm;
  logic [31:0]                  s1_data;
  logic [31:0]                  rd_a;
  logic [31:0]                  rd_b;
  logic                         va;
  logic                         vb;
  logic                         hit_a;
  logic                         hit_b;
  logic [31:0]                  fwd_val;

  logic [rialu_pkg::SR_W-1:0]   sr;
  logic [rialu_pkg::SR_W-1:0]   sr_next;

  logic                         req_fire;
  logic                         s1_adv;
  logic                         s1_fire;
  logic [3:0]                   addr_a;

  logic                         wr;
  logic [3:0]                   widx;
  logic [31:0]                  val;
  logic                         wb_en;

  logic [31:0]                  rn;
  logic [31:0]                  rm;
  logic                         t;
  logic [32:0]                  csum;
  logic [32:0]                  dsum;
  logic [31:0]                  sh;
  logic [31:0]                  x;
  logic                         qd;

  // handshake
  assign s1_adv   = !rsp_valid || rsp_ready;
  assign s1_fire  = s1_v && s1_adv;
  assign req_ready = !s1_v || s1_adv;
  assign req_fire = req_valid && req_ready;
  assign wb_en    = s1_fire && wr;

  // r0 is the first operand of and immediate and compare immediate
  assign addr_a = (req.kind == rialu_pkg::K_ANDI || req.kind == rialu_pkg::K_CMPIM) ?
                  4'd0 : req.dest_reg;

  // register file write port
  always_ff @(posedge clk) begin
    if (wb_en) begin
      mem[widx] <= val;
    end
  end

  // register file read ports, read data registered
  always_ff @(posedge clk) begin
    if (req_fire) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[req.src_reg];
    end
  end

  // valid bits and forwarding of a write in the read cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wb_en) begin
      vld[widx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      va      <= vld[addr_a];
      vb      <= vld[req.src_reg];
      hit_a   <= wb_en && (widx == addr_a);
      hit_b   <= wb_en && (widx == req.src_reg);
      fwd_val <= val;
      s1_kind <= req.kind;
      s1_dest <= req.dest_reg;
      s1_imm  <= req.imm_byte;
      s1_data <= req.load_data;
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (req_fire) begin
      s1_v <= 1'b1;
    end else if (s1_fire) begin
      s1_v <= 1'b0;
    end
  end

  // operand selection
  assign rn = hit_a ? fwd_val : (va ? rd_a : 32'd0);
  assign rm = hit_b ? fwd_val : (vb ? rd_b : 32'd0);
  assign t  = sr[rialu_pkg::SR_T];

  // shared adders
  assign csum = {1'b0, rn} + {1'b0, rm} + {32'd0, t};
  assign sh   = {rn[30:0], t};
  assign dsum = (sr[rialu_pkg::SR_Q] == sr[rialu_pkg::SR_M]) ?
                ({1'b0, sh} - {1'b0, rm}) : ({1'b0, sh} + {1'b0, rm});
  assign x    = rn ^ rm;
  assign qd   = rn[31] ^ dsum[32] ^ sr[rialu_pkg::SR_M];

  // execute
  always_comb begin
    sr_next = sr;
    wr      = 1'b0;
    widx    = s1_dest;
    val     = 32'd0;
    unique case (s1_kind)
      rialu_pkg::K_ADD: begin
        val = rn + rm;
        wr  = 1'b1;
      end
      rialu_pkg::K_ADDI: begin
        val = rn + rialu_pkg::sext8(s1_imm);
        wr  = 1'b1;
      end
      rialu_pkg::K_ADDC: begin
        val = csum[31:0];
        wr  = 1'b1;
        sr_next[rialu_pkg::SR_T] = csum[32];
      end
      rialu_pkg::K_ADDV: begin
        val = rn + rm;
        wr  = 1'b1;
        sr_next[rialu_pkg::SR_T] = (rn[31] ^ val[31]) & (rm[31] ^ val[31]);
      end
      rialu_pkg::K_AND: begin
        val = rn & rm;
        wr  = 1'b1;
      end
      rialu_pkg::K_ANDI: begin
        widx = 4'd0;
        val  = rn & {24'd0, s1_imm};
        wr   = 1'b1;
      end
      rialu_pkg::K_CMPEQ:  sr_next[rialu_pkg::SR_T] = (rn == rm);
      rialu_pkg::K_CMPGE:  sr_next[rialu_pkg::SR_T] = ($signed(rn) >= $signed(rm));
      rialu_pkg::K_CMPGT:  sr_next[rialu_pkg::SR_T] = ($signed(rn) > $signed(rm));
      rialu_pkg::K_CMPHI:  sr_next[rialu_pkg::SR_T] = (rn > rm);
      rialu_pkg::K_CMPHS:  sr_next[rialu_pkg::SR_T] = (rn >= rm);
      rialu_pkg::K_CMPPL:  sr_next[rialu_pkg::SR_T] = !rn[31] && (rn != 32'd0);
      rialu_pkg::K_CMPPZ:  sr_next[rialu_pkg::SR_T] = !rn[31];
      rialu_pkg::K_CMPSTR: begin
        sr_next[rialu_pkg::SR_T] = (x[31:24] == 8'd0) || (x[23:16] == 8'd0) ||
                                   (x[15:8] == 8'd0) || (x[7:0] == 8'd0);
      end
      rialu_pkg::K_CMPIM:  sr_next[rialu_pkg::SR_T] = (rn == rialu_pkg::sext8(s1_imm));
      rialu_pkg::K_DIV0S: begin
        sr_next[rialu_pkg::SR_Q] = rn[31];
        sr_next[rialu_pkg::SR_M] = rm[31];
        sr_next[rialu_pkg::SR_T] = rn[31] ^ rm[31];
      end
      rialu_pkg::K_DIV0U: begin
        sr_next[rialu_pkg::SR_Q] = 1'b0;
        sr_next[rialu_pkg::SR_M] = 1'b0;
        sr_next[rialu_pkg::SR_T] = 1'b0;
      end
      rialu_pkg::K_DIV1: begin
        // one restoring-free division step: shift in T, add or subtract divisor
        val = dsum[31:0];
        wr  = 1'b1;
        sr_next[rialu_pkg::SR_Q] = qd;
        sr_next[rialu_pkg::SR_T] = (qd == sr[rialu_pkg::SR_M]);
      end
      rialu_pkg::K_DT: begin
        val = rn - 32'd1;
        wr  = 1'b1;
        sr_next[rialu_pkg::SR_T] = (rn == 32'd1);
      end
      rialu_pkg::K_EXTSB: begin
        val = rialu_pkg::sext8(rm[7:0]);
        wr  = 1'b1;
      end
      rialu_pkg::K_EXTSW: begin
        val = rialu_pkg::sext16(rm[15:0]);
        wr  = 1'b1;
      end
      rialu_pkg::K_EXTUB: begin
        val = {24'd0, rm[7:0]};
        wr  = 1'b1;
      end
      rialu_pkg::K_EXTUW: begin
        val = {16'd0, rm[15:0]};
        wr  = 1'b1;
      end
      rialu_pkg::K_MOV: begin
        val = rm;
        wr  = 1'b1;
      end
      rialu_pkg::K_CLRT:  sr_next[rialu_pkg::SR_T] = 1'b0;
      rialu_pkg::K_LDCSR: sr_next = rm[rialu_pkg::SR_W-1:0] & rialu_pkg::SR_MASK;
      rialu_pkg::K_LDB: begin
        val = rialu_pkg::sext8(s1_data[7:0]);
        wr  = 1'b1;
      end
      rialu_pkg::K_LDW: begin
        val = rialu_pkg::sext16(s1_data[15:0]);
        wr  = 1'b1;
      end
      rialu_pkg::K_LDL: begin
        val = s1_data;
        wr  = 1'b1;
      end
      default: begin
        wr = 1'b0;
      end
    endcase
  end

  // status register
  always_ff @(posedge clk) begin
    if (rst) begin
      sr <= '0;
    end else if (s1_fire) begin
      sr <= sr_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      rsp.reg_written   <= wr;
      rsp.written_index <= wr ? widx : 4'd0;
      rsp.written_value <= wr ? val : 32'd0;
      rsp.t_flag        <= sr_next[rialu_pkg::SR_T];
      rsp.q_flag        <= sr_next[rialu_pkg::SR_Q];
      rsp.m_flag        <= sr_next[rialu_pkg::SR_M];
    end
  end

  // checks
  `ASSERT_CLK(a_no_accept_on_stall, (s1_v && !s1_adv) |-> !req_fire, "accept while stalled")
  `ASSERT_CLK(a_wb_needs_stage, wb_en |-> s1_v, "write back without an instruction")
  `ASSERT_CLK(a_rsp_from_stage, $rose(rsp_valid) |-> $past(s1_v), "result without execute")
  `ASSERT_CLK(a_nowrite_zero, (rsp_valid && !rsp.reg_written) |-> (rsp.written_index == 4'd0 && rsp.written_value == 32'd0), "no-write result not zero")
  `ASSERT_ALWAYS(a_vld_cleared, $past(rst) |-> (vld == '0), "valid bits not cleared")

endmodule

// ----- dv/tb_risc_integer_alu_with_flag_bits_core.sv -----
// testbench for the integer alu core: queued instruction driver, checking monitor, watchdog
// depends on rialu_pkg and risc_integer_alu_with_flag_bits_core from hdl
`timescale 1ns / 1ps

module tb_risc_integer_alu_with_flag_bits_core;

  localparam int N_ITEMS = 1150;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;
  localparam int HOLD_AT = 400;
  localparam int MAX_REPORTS = 10;
  // kinds with no operation behind them
  localparam logic [4:0] K_UNUSED_LO = 5'd29;
  localparam logic [4:0] K_UNUSED_HI = 5'd31;

  typedef struct {
    rialu_pkg::req_t instr;
    bit              drain_first;
  } pend_instr_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  rialu_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rialu_pkg::rsp_t rsp;

  // architectural state as the checker sees it
  logic [31:0] gpr_model [rialu_pkg::NREGS];
  logic [rialu_pkg::SR_W-1:0] sr_model;

  pend_instr_t instr_q[$];
  rialu_pkg::rsp_t retire_q[$];
  bit drain_pending;
  int n_accepted;
  int n_retired;
  int err_count;
  int idle_cycles;

  risc_integer_alu_with_flag_bits_core u_top (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always #5 clk = ~clk;

  // execute one instruction against the model state, return its retirement record
  function automatic rialu_pkg::rsp_t execute_instr(input rialu_pkg::req_t r);
    logic [31:0] rn, rm, val, sh, imm_s, x;
    logic [32:0] wide;
    logic t, wr, borrow, qn, mb, oq;
    logic [3:0] widx;
    rialu_pkg::rsp_t o;
    rn = gpr_model[r.dest_reg];
    rm = gpr_model[r.src_reg];
    t = sr_model[rialu_pkg::SR_T];
    imm_s = {{24{r.imm_byte[7]}}, r.imm_byte};
    wr = 1'b0;
    widx = r.dest_reg;
    val = '0;
    case (r.kind)
      rialu_pkg::K_ADD: begin
        val = rn + rm;
        wr = 1'b1;
      end
      rialu_pkg::K_ADDI: begin
        val = rn + imm_s;
        wr = 1'b1;
      end
      rialu_pkg::K_ADDC: begin
        wide = {1'b0, rn} + {1'b0, rm} + {32'd0, t};
        val = wide[31:0];
        wr = 1'b1;
        sr_model[rialu_pkg::SR_T] = wide[32];
      end
      rialu_pkg::K_ADDV: begin
        val = rn + rm;
        wr = 1'b1;
        sr_model[rialu_pkg::SR_T] = (rn[31] ^ val[31]) & (rm[31] ^ val[31]);
      end
      rialu_pkg::K_AND: begin
        val = rn & rm;
        wr = 1'b1;
      end
      rialu_pkg::K_ANDI: begin
        widx = 4'd0;
        val = gpr_model[0] & {24'd0, r.imm_byte};
        wr = 1'b1;
      end
      rialu_pkg::K_CMPEQ: sr_model[rialu_pkg::SR_T] = (rn == rm);
      rialu_pkg::K_CMPGE: sr_model[rialu_pkg::SR_T] = ($signed(rn) >= $signed(rm));
      rialu_pkg::K_CMPGT: sr_model[rialu_pkg::SR_T] = ($signed(rn) > $signed(rm));
      rialu_pkg::K_CMPHI: sr_model[rialu_pkg::SR_T] = (rn > rm);
      rialu_pkg::K_CMPHS: sr_model[rialu_pkg::SR_T] = (rn >= rm);
      rialu_pkg::K_CMPPL: sr_model[rialu_pkg::SR_T] = !rn[31] && (rn != 0);
      rialu_pkg::K_CMPPZ: sr_model[rialu_pkg::SR_T] = !rn[31];
      rialu_pkg::K_CMPSTR: begin
        x = rn ^ rm;
        sr_model[rialu_pkg::SR_T] = (x[31:24] == 0) || (x[23:16] == 0) ||
                                    (x[15:8] == 0) || (x[7:0] == 0);
      end
      rialu_pkg::K_CMPIM: sr_model[rialu_pkg::SR_T] = (gpr_model[0] == imm_s);
      rialu_pkg::K_DIV0S: begin
        sr_model[rialu_pkg::SR_Q] = rn[31];
        sr_model[rialu_pkg::SR_M] = rm[31];
        sr_model[rialu_pkg::SR_T] = rn[31] ^ rm[31];
      end
      rialu_pkg::K_DIV0U: begin
        sr_model[rialu_pkg::SR_Q] = 1'b0;
        sr_model[rialu_pkg::SR_M] = 1'b0;
        sr_model[rialu_pkg::SR_T] = 1'b0;
      end
      rialu_pkg::K_DIV1: begin
        // rm was read before rn shifts, so rn == rm sees the old value
        oq = sr_model[rialu_pkg::SR_Q];
        mb = sr_model[rialu_pkg::SR_M];
        sh = {rn[30:0], t};
        if (oq == mb) begin
          val = sh - rm;
          borrow = (val > sh);
        end else begin
          val = sh + rm;
          borrow = (val < sh);
        end
        qn = rn[31] ^ borrow ^ mb;
        sr_model[rialu_pkg::SR_Q] = qn;
        sr_model[rialu_pkg::SR_T] = (qn == mb);
        wr = 1'b1;
      end
      rialu_pkg::K_DT: begin
        val = rn - 32'd1;
        wr = 1'b1;
        sr_model[rialu_pkg::SR_T] = (val == 0);
      end
      rialu_pkg::K_EXTSB: begin
        val = {{24{rm[7]}}, rm[7:0]};
        wr = 1'b1;
      end
      rialu_pkg::K_EXTSW: begin
        val = {{16{rm[15]}}, rm[15:0]};
        wr = 1'b1;
      end
      rialu_pkg::K_EXTUB: begin
        val = {24'd0, rm[7:0]};
        wr = 1'b1;
      end
      rialu_pkg::K_EXTUW: begin
        val = {16'd0, rm[15:0]};
        wr = 1'b1;
      end
      rialu_pkg::K_MOV: begin
        val = rm;
        wr = 1'b1;
      end
      rialu_pkg::K_CLRT: sr_model[rialu_pkg::SR_T] = 1'b0;
      // only the implemented status bits survive
      rialu_pkg::K_LDCSR: sr_model = rm[rialu_pkg::SR_W-1:0] & rialu_pkg::SR_MASK;
      rialu_pkg::K_LDB: begin
        val = {{24{r.load_data[7]}}, r.load_data[7:0]};
        wr = 1'b1;
      end
      rialu_pkg::K_LDW: begin
        val = {{16{r.load_data[15]}}, r.load_data[15:0]};
        wr = 1'b1;
      end
      rialu_pkg::K_LDL: begin
        val = r.load_data;
        wr = 1'b1;
      end
      default: ;
    endcase
    if (wr) begin
      gpr_model[widx] = val;
    end else begin
      widx = 4'd0;
      val = '0;
    end
    o.reg_written = wr;
    o.written_index = widx;
    o.written_value = val;
    o.t_flag = sr_model[rialu_pkg::SR_T];
    o.q_flag = sr_model[rialu_pkg::SR_Q];
    o.m_flag = sr_model[rialu_pkg::SR_M];
    return o;
  endfunction

  task automatic add_instr(input logic [4:0] k, input logic [3:0] n, input logic [3:0] m,
                           input logic [7:0] imm, input logic [31:0] data);
    pend_instr_t p;
    p.instr.kind = k;
    p.instr.dest_reg = n;
    p.instr.src_reg = m;
    p.instr.imm_byte = imm;
    p.instr.load_data = data;
    p.drain_first = drain_pending;
    drain_pending = 1'b0;
    instr_q.push_back(p);
  endtask

  // operand words biased toward sign and byte boundaries
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 15))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'h0000_0001;
      5: return 32'h0000_0080;
      6: return 32'h0000_007F;
      7: return 32'h0000_8000;
      8: return 32'h0000_7FFF;
      9: return {24'($urandom_range(0, 255)), 8'h00} ^ 32'h1234_5678;
      default: return $urandom;
    endcase
  endfunction

  // short directed opening: extremes and the corner behaviors
  task automatic build_directed();
    add_instr(rialu_pkg::K_LDL, 4'd1, 4'd0, 8'h00, 32'hFFFF_FFFF);
    add_instr(rialu_pkg::K_LDL, 4'd2, 4'd0, 8'hFF, 32'h8000_0000);
    add_instr(rialu_pkg::K_LDL, 4'd3, 4'd0, 8'h00, 32'h7FFF_FFFF);
    add_instr(rialu_pkg::K_LDB, 4'd4, 4'd0, 8'h00, 32'h0000_0080);
    add_instr(rialu_pkg::K_LDW, 4'd5, 4'd0, 8'h00, 32'h1234_8000);
    // unsigned carry out of add with carry, then with carry in
    add_instr(rialu_pkg::K_ADDC, 4'd1, 4'd1, 8'h00, 32'h0);
    add_instr(rialu_pkg::K_ADDC, 4'd0, 4'd3, 8'h00, 32'h0);
    add_instr(rialu_pkg::K_ADDV, 4'd3, 4'd3, 8'h00, 32'h0);
    add_instr(rialu_pkg::K_ADD, 4'd2, 4'd2, 8'h00, 32'h0);
    add_instr(rialu_pkg::K_ADDI, 4'd5, 4'd0, 8'h80, 32'h0);
    add_instr(rialu_pkg::K_ANDI, 4'd7, 4'd9, 8'hFF, 32'hFFFF_FFFF);
    add_instr(rialu_pkg::K_CMPIM, 4'd0, 4'd0, 8'hFF, 32'h0);
    add_instr(rialu_pkg::K_CMPSTR, 4'd1, 4'd4, 8'h00, 32'h0);
    add_instr(rialu_pkg::K_CMPGE, 4'd5, 4'd3, 8'h00, 32'h0);
    add_instr(rialu_pkg::K_CMPHI, 4'd5, 4'd3, 8'h00, 32'h0);
    // division step with q = m = 0 and rn == rm
    add_instr(rialu_pkg::K_DIV0U, 4'd0, 4'd0, 8'h00, 32'h0);
    add_instr(rialu_pkg::K_DIV1, 4'd1, 4'd1, 8'h00, 32'h0);
    add_instr(rialu_pkg::K_DIV0S, 4'd5, 4'd3, 8'h00, 32'h0);
    add_instr(rialu_pkg::K_DIV1, 4'd4, 4'd3, 8'h00, 32'h0);
    add_instr(rialu_pkg::K_LDL, 4'd7, 4'd0, 8'h00, 32'h0000_0001);
    add_instr(rialu_pkg::K_DT, 4'd7, 4'd0, 8'h00, 32'h0);
    // load status from register 4 keeps the implemented bits only
    add_instr(rialu_pkg::K_LDCSR, 4'd0, 4'd4, 8'h00, 32'h0);
    add_instr(K_UNUSED_LO, 4'd15, 4'd15, 8'hFF, 32'hFFFF_FFFF);
    add_instr(K_UNUSED_HI, 4'd3, 4'd3, 8'h00, 32'h0);
    add_instr(rialu_pkg::K_CLRT, 4'd0, 4'd0, 8'h00, 32'h0);
  endtask

  // random part: well-formed division runs, loads with corner data, status loads, unused kinds and random operations
  task automatic build_random();
    int sel, next_drain, len;
    logic [3:0] n, m;
    logic [4:0] k;
    next_drain = 300;
    while (instr_q.size() < N_ITEMS) begin
      if (instr_q.size() >= next_drain) begin
        drain_pending = 1'b1;
        next_drain += 450;
      end
      sel = $urandom_range(0, 99);
      n = 4'($urandom_range(0, 15));
      m = ($urandom_range(0, 3) == 0) ? n : 4'($urandom_range(0, 15));
      if (sel < 15) begin
        k = 5'(rialu_pkg::K_LDB + $urandom_range(0, 2));
        add_instr(k, n, m, 8'($urandom), pick_word());
      end else if (sel < 27) begin
        if ($urandom_range(0, 1)) add_instr(rialu_pkg::K_LDL, n, m, 8'($urandom), pick_word());
        if ($urandom_range(0, 1)) add_instr(rialu_pkg::K_LDL, m, n, 8'($urandom), pick_word());
        k = $urandom_range(0, 1) ? rialu_pkg::K_DIV0S : rialu_pkg::K_DIV0U;
        add_instr(k, n, m, 8'($urandom), $urandom);
        len = $urandom_range(1, 32);
        repeat (len) add_instr(rialu_pkg::K_DIV1, n, m, 8'($urandom), $urandom);
      end else if (sel < 32) begin
        add_instr(rialu_pkg::K_LDL, m, n, 8'($urandom), $urandom);
        add_instr(rialu_pkg::K_LDCSR, n, m, 8'($urandom), $urandom);
      end else if (sel < 36) begin
        k = 5'($urandom_range(K_UNUSED_LO, K_UNUSED_HI));
        add_instr(k, n, m, 8'($urandom), $urandom);
      end else begin
        k = 5'($urandom_range(rialu_pkg::K_ADD, rialu_pkg::K_LDL));
        add_instr(k, n, m, 8'($urandom), pick_word());
      end
    end
  endtask

  // driver: bursts with random gaps, optional drain before a marked transaction
  int gap_left;
  int burst_left;
  always @(posedge clk) begin
    logic fire;
    logic nxt_valid;
    rialu_pkg::req_t nxt_req;
    if (rst) begin
      req_valid <= 1'b0;
      gap_left = 0;
      burst_left = 0;
    end else begin
      fire = req_valid && req_ready;
      nxt_valid = req_valid;
      nxt_req = req;
      if (fire) begin
        retire_q.push_back(execute_instr(req));
        n_accepted++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && instr_q.size() != 0) begin
        if (instr_q[0].drain_first && retire_q.size() != 0) begin
          // hold until every outstanding result has retired
        end else if (gap_left > 0) begin
          gap_left--;
        end else begin
          nxt_req = instr_q[0].instr;
          instr_q.pop_front();
          nxt_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      req_valid <= nxt_valid;
      req <= nxt_req;
    end
  end

  // monitor: back-pressure pattern, one long hold, in-order compare
  int hold_left;
  bit hold_done;
  int rdy_mode;
  int mode_left;
  int rdy_phase;
  always @(posedge clk) begin
    rialu_pkg::rsp_t want;
    logic nxt_ready;
    if (rst) begin
      rsp_ready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
      mode_left = 0;
      rdy_phase = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        n_retired++;
        if (retire_q.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("unexpected result transaction: wr=%0b idx=%0d val=%h t=%0b q=%0b m=%0b",
                     rsp.reg_written, rsp.written_index, rsp.written_value,
                     rsp.t_flag, rsp.q_flag, rsp.m_flag);
        end else begin
          want = retire_q.pop_front();
          if (rsp.reg_written !== want.reg_written || rsp.written_index !== want.written_index ||
              rsp.written_value !== want.written_value || rsp.t_flag !== want.t_flag ||
              rsp.q_flag !== want.q_flag || rsp.m_flag !== want.m_flag) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("mismatch on result %0d: exp wr=%0b idx=%0d val=%h t=%0b q=%0b m=%0b,",
                       n_retired, want.reg_written, want.written_index, want.written_value,
                       want.t_flag, want.q_flag, want.m_flag,
                       " got wr=%0b idx=%0d val=%h t=%0b q=%0b m=%0b",
                       rsp.reg_written, rsp.written_index, rsp.written_value,
                       rsp.t_flag, rsp.q_flag, rsp.m_flag);
          end
        end
      end
      rdy_phase++;
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if (!hold_done && n_accepted >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        nxt_ready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rdy_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (rdy_mode)
          0: nxt_ready = 1'b1;
          1: nxt_ready = 1'($urandom_range(0, 1));
          2: nxt_ready = ($urandom_range(0, 4) != 0);
          default: nxt_ready = (rdy_phase % 3 != 0);
        endcase
      end
      rsp_ready <= nxt_ready;
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // reset, program build, end of run
  initial begin
    for (int i = 0; i < rialu_pkg::NREGS; i++) gpr_model[i] = '0;
    sr_model = '0;
    drain_pending = 1'b0;
    n_accepted = 0;
    n_retired = 0;
    err_count = 0;
    idle_cycles = 0;
    build_directed();
    build_random();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (instr_q.size() != 0 || req_valid) @(posedge clk);
    while (retire_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0 && retire_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/rialu_pkg.sv
hdl/risc_integer_alu_with_flag_bits_core.sv
dv/tb_risc_integer_alu_with_flag_bits_core.sv
